>>> sv/bpd_pkg.sv
package bpd_pkg;

	// fixed sizes of the block
	localparam int BAND_COUNT    = 7;
	localparam int SAMPLE_BITS   = 10;
	localparam int BAND_BITS     = 3;
	localparam int CFG_BITS      = 10;
	localparam int CFG_IDX_BITS  = 2;
	localparam int LED_BITS      = 8;

	localparam int BAND_IDX_BITS = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	localparam int HIST_BITS     = 2 * SAMPLE_BITS;
	localparam int SUM_BITS      = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;

	localparam logic [BAND_IDX_BITS-1:0] BAND_LAST = BAND_IDX_BITS'(BAND_COUNT - 1);

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_FLOOR    = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_JUMP_THRESHOLD = CFG_IDX_BITS'(1);

	// register reset values
	localparam logic [CFG_BITS-1:0] FLOOR_RESET = CFG_BITS'(90);
	localparam logic [CFG_BITS-1:0] JUMP_RESET  = CFG_BITS'(50);

	typedef struct packed {
		logic [CFG_BITS-1:0] floor_lvl;
		logic [CFG_BITS-1:0] jump;
	} cfg_t;

	// history and flag update request shared by the lanes and the merge stage
	typedef struct packed {
		logic                     wr;
		logic [BAND_IDX_BITS-1:0] idx;
	} upd_t;

	typedef struct packed {
		logic [BAND_BITS-1:0] band_done;
		logic                 peak_first;
		logic                 peak_second;
		logic                 frame_ready;
		logic [LED_BITS-1:0]  led_upper;
		logic [LED_BITS-1:0]  led_lower;
	} res_t;

	// led bit of a band: the last band goes to the top bit
	function automatic logic [2:0] led_pos(input int k);
		if (k == BAND_COUNT - 1)
			return 3'd7;
		return 3'(BAND_COUNT - 1 - k);
	endfunction

endpackage

>>> sv/bpd_lane.sv
module bpd_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bpd_pkg::upd_t                    upd,
	input  bpd_pkg::cfg_t                    cfg,
	input  logic [bpd_pkg::SAMPLE_BITS-1:0]  level,
	output logic                             peak
);
	import bpd_pkg::*;

	logic [HIST_BITS-1:0]   hist_q [BAND_COUNT];
	logic [SAMPLE_BITS-1:0] prev;
	logic [SAMPLE_BITS-1:0] older;
	logic [SUM_BITS-1:0]    rise_lim;

	// previous and two-back readings of the addressed band
	assign prev  = hist_q[upd.idx][SAMPLE_BITS-1:0];
	assign older = hist_q[upd.idx][HIST_BITS-1:SAMPLE_BITS];

	// peak test
	assign rise_lim = SUM_BITS'(prev) + SUM_BITS'(cfg.jump);
	assign peak = (SUM_BITS'(level) >= SUM_BITS'(cfg.floor_lvl)) &&
		((SUM_BITS'(level) > rise_lim) || (level > older));

	// shift the new reading into the band history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAND_COUNT; i++)
				hist_q[i] <= '0;
		end else if (upd.wr) begin
			hist_q[upd.idx] <= {prev, level};
		end
	end

endmodule

>>> sv/bpd_merge.sv
module bpd_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpd_pkg::upd_t                 upd,
	input  logic                          pk_first,
	input  logic                          pk_second,
	output logic                          frame_ready,
	output logic [bpd_pkg::LED_BITS-1:0]  led_upper,
	output logic [bpd_pkg::LED_BITS-1:0]  led_lower
);
	import bpd_pkg::*;

	logic [BAND_COUNT-1:0] flags_first_q;
	logic [BAND_COUNT-1:0] flags_second_q;
	logic [BAND_COUNT-1:0] first_nx;
	logic [BAND_COUNT-1:0] second_nx;

	// frame flags with this word's lane results folded in
	always_comb begin
		first_nx  = flags_first_q;
		second_nx = flags_second_q;
		if (upd.wr) begin
			first_nx[upd.idx]  = pk_first;
			second_nx[upd.idx] = pk_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_first_q  <= '0;
			flags_second_q <= '0;
		end else begin
			flags_first_q  <= first_nx;
			flags_second_q <= second_nx;
		end
	end

	assign frame_ready = upd.wr && (upd.idx == BAND_LAST);

	// led bytes, only on the last band
	always_comb begin
		led_upper = '0;
		led_lower = '0;
		if (frame_ready) begin
			for (int k = 0; k < BAND_COUNT; k++) begin
				led_upper[led_pos(k)] = led_upper[led_pos(k)] | first_nx[k];
				led_lower[led_pos(k)] = led_lower[led_pos(k)] | second_nx[k];
			end
		end
	end

endmodule

>>> sv/band_peak_detector_core.sv
// Band peak detector for a seven-band, two-channel spectrum analyser. Each
// input word carries one band reading for both channels; two lanes, one per
// channel, judge the reading against the band's two earlier readings, and a
// merge stage gathers the flags of the frame and builds the two LED bytes on
// the last band. A word can be taken every clock cycle while in_stall is low;
// each lane reads, compares and writes back its band history on acceptance.
// The result word goes to an output register, or to a skid register behind it
// while the output word is held; this keeps in_stall registered, so the input
// side stops only once two result words are waiting. A word with a band index
// beyond the last band is accepted and dropped without a result. Configuration
// writes are always ready and should be made only while the block is idle.
module band_peak_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bpd_pkg::BAND_BITS-1:0]     band,
	input  logic [bpd_pkg::SAMPLE_BITS-1:0]   level_first,
	input  logic [bpd_pkg::SAMPLE_BITS-1:0]   level_second,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bpd_pkg::BAND_BITS-1:0]     band_done,
	output logic                              peak_first,
	output logic                              peak_second,
	output logic                              frame_ready,
	output logic [bpd_pkg::LED_BITS-1:0]      led_upper,
	output logic [bpd_pkg::LED_BITS-1:0]      led_lower,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bpd_pkg::CFG_BITS-1:0]      cfg_data
);
	import bpd_pkg::*;

	cfg_t  cfg_q;
	upd_t  upd;
	res_t  res;
	res_t  out_q;
	res_t  skid_q;
	logic  out_valid_q;
	logic  skid_valid_q;
	logic  acc;
	logic  in_range;
	logic  take;
	logic  lane_pk_first;
	logic  lane_pk_second;
	logic  mrg_ready;
	logic [LED_BITS-1:0] mrg_upper;
	logic [LED_BITS-1:0] mrg_lower;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_lvl <= FLOOR_RESET;
			cfg_q.jump      <= JUMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEVEL_FLOOR:    cfg_q.floor_lvl <= cfg_data;
				CFG_JUMP_THRESHOLD: cfg_q.jump      <= cfg_data;
				default:            ;
			endcase
		end
	end

	// input acceptance
	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !skid_valid_q;
	assign in_range = ({1'b0, band} < (BAND_BITS + 1)'(BAND_COUNT));
	assign upd.wr   = acc && in_range;
	assign upd.idx  = band[BAND_IDX_BITS-1:0];

	// one lane per channel
	bpd_lane u_lane_first (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.cfg    (cfg_q),
		.level  (level_first),
		.peak   (lane_pk_first)
	);

	bpd_lane u_lane_second (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.cfg    (cfg_q),
		.level  (level_second),
		.peak   (lane_pk_second)
	);

	// frame flag gathering and led bytes
	bpd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.pk_first    (lane_pk_first),
		.pk_second   (lane_pk_second),
		.frame_ready (mrg_ready),
		.led_upper   (mrg_upper),
		.led_lower   (mrg_lower)
	);

	always_comb begin
		res.band_done   = band;
		res.peak_first  = lane_pk_first;
		res.peak_second = lane_pk_second;
		res.frame_ready = mrg_ready;
		res.led_upper   = mrg_upper;
		res.led_lower   = mrg_lower;
	end

	// output register and skid register
	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take)
				skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q <= upd.wr;
		end else if (upd.wr) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				out_q <= skid_q;
		end else if (!out_valid_q || take) begin
			out_q <= res;
		end else if (upd.wr) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign band_done   = out_q.band_done;
	assign peak_first  = out_q.peak_first;
	assign peak_second = out_q.peak_second;
	assign frame_ready = out_q.frame_ready;
	assign led_upper   = out_q.led_upper;
	assign led_lower   = out_q.led_lower;

endmodule

>>> sv/bpd_checker.sv
module bpd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [bpd_pkg::BAND_BITS-1:0]     band,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [bpd_pkg::BAND_BITS-1:0]     band_done,
	input  logic                              peak_first,
	input  logic                              peak_second,
	input  logic                              frame_ready,
	input  logic [bpd_pkg::LED_BITS-1:0]      led_upper,
	input  logic [bpd_pkg::LED_BITS-1:0]      led_lower
);
	import bpd_pkg::*;

	// a held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(band_done) &&
		$stable(peak_first) && $stable(peak_second) && $stable(frame_ready) &&
		$stable(led_upper) && $stable(led_lower))
		else $error("result word changed while stalled");

	// led bytes come only with the last band
	a_ready_band: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ready |-> band_done == BAND_BITS'(BAND_COUNT - 1))
		else $error("frame_ready on a band other than the last");

	a_led_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ready |-> led_upper == '0 && led_lower == '0)
		else $error("led bytes set outside the last band");

	// an accepted in-range word reaches an empty output next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid &&
		({1'b0, band} < (BAND_BITS + 1)'(BAND_COUNT))
		|=> out_valid && band_done == $past(band))
		else $error("result word missing after acceptance");

endmodule

bind band_peak_detector_core bpd_checker u_bpd_checker (.*);
